// ----- design/mirfm_pkg.sv -----
// ----------------------------------------------------------------------------
// mirfm_pkg: shared types and constants of the masked IP rule table
// Field widths, table geometry and the packed rule entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package mirfm_pkg;

  localparam int unsigned MAX_RULES  = 256;
  localparam int unsigned TAG_BITS   = 16;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned IDX_W      = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_RULES + 1);
  // stored tag bits: the field is 16 bits, and only TAG_BITS of it are kept
  localparam int unsigned TAG_KEEP_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

  localparam logic [WORD_W-1:0] V4_HI_MASK = 64'hFFFF_FFFF_0000_0000;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0]     value_hi;
    logic [WORD_W-1:0]     value_lo;
    logic [WORD_W-1:0]     mask_hi;
    logic [WORD_W-1:0]     mask_lo;
    logic                  kind_v4;
    logic [TAG_KEEP_W-1:0] tag;
  } rule_t;

endpackage

`default_nettype wire

// ----- design/mirfm_req_if.sv -----
// ----------------------------------------------------------------------------
// mirfm_req_if: request channel of the masked IP rule table
// Valid/ready handshake carrying one append or lookup transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mirfm_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic                          is_ipv4;
  logic [mirfm_pkg::WORD_W-1:0]  addr_hi;
  logic [mirfm_pkg::WORD_W-1:0]  addr_lo;
  logic [mirfm_pkg::WORD_W-1:0]  mask_hi;
  logic [mirfm_pkg::WORD_W-1:0]  mask_lo;
  logic [mirfm_pkg::TAG_W-1:0]   rule_tag;

  modport source (
    output valid, req_type, is_ipv4, addr_hi, addr_lo, mask_hi, mask_lo, rule_tag,
    input  ready
  );
  modport sink (
    input  valid, req_type, is_ipv4, addr_hi, addr_lo, mask_hi, mask_lo, rule_tag,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/mirfm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mirfm_rsp_if: response channel of the masked IP rule table
// Valid/ready handshake carrying one result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mirfm_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic                        matched;
  logic [mirfm_pkg::TAG_W-1:0] flags_tag;

  modport source (
    output valid, status, matched, flags_tag,
    input  ready
  );
  modport sink (
    input  valid, status, matched, flags_tag,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/masked_ip_rule_first_match.sv -----
// ----------------------------------------------------------------------------
// masked_ip_rule_first_match: first-match table of masked IPv4/IPv6 rules
//
// req_i takes one transaction at a time: an append stores a rule (value,
// mask, kind, tag) at the next free slot, or reports status=1 when the
// table already holds MAX_RULES rules. A lookup walks the rules in the
// order they were appended and returns the tag of the first one of the
// same kind whose masked compare hits (4 bytes for IPv4, 16 for IPv6).
// rsp_o returns exactly one result per request.
// A lookup issues one rule read per cycle from the read port of the rule
// memory and compares each rule in the cycle after, in a single compare
// unit; it stops at the first hit or after the last rule, and an empty
// table answers with no read at all. req_i.ready is low while a
// transaction is in work and rises together with rsp_o.valid, when its
// result moves into the output register.
// A finished result waits in the output register while req_i already takes
// the next transaction; a stalled rsp_o then holds back the one after it.
// Reset empties the table (rule count to zero); the memory needs no clear.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_ip_rule_first_match (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mirfm_req_if.sink   req_i,
  mirfm_rsp_if.source rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                          state_q;
  logic [mirfm_pkg::CNT_W-1:0]     count_q;
  logic [mirfm_pkg::IDX_W-1:0]     idx_q;
  logic                            issue_q;
  logic                            pend_q;
  logic                            rd_last_q;

  logic                            key_v4_q;
  logic [mirfm_pkg::WORD_W-1:0]    key_hi_q;
  logic [mirfm_pkg::WORD_W-1:0]    key_lo_q;

  logic                            res_status_q;
  logic                            res_matched_q;
  logic [mirfm_pkg::TAG_W-1:0]     res_tag_q;

  logic                            out_valid_q;
  logic                            out_status_q;
  logic                            out_matched_q;
  logic [mirfm_pkg::TAG_W-1:0]     out_tag_q;

  mirfm_pkg::rule_t                mem [mirfm_pkg::MAX_RULES];
  mirfm_pkg::rule_t                rd_q;
  mirfm_pkg::rule_t                wr_rule;

  logic                            accept;
  logic                            full;
  logic                            wr_en;
  logic                            last_idx;
  logic                            kind_ok;
  logic                            hit;
  logic                            out_free;

  assign accept   = req_i.valid && req_i.ready;
  assign full     = (count_q == mirfm_pkg::CNT_W'(mirfm_pkg::MAX_RULES));
  assign wr_en    = accept && (req_i.req_type == mirfm_pkg::REQ_APPEND) && !full;
  assign last_idx = ({1'b0, idx_q} == mirfm_pkg::CNT_W'(count_q - 1'b1));
  assign out_free = !out_valid_q || rsp_o.ready;

  assign wr_rule.value_hi = req_i.addr_hi;
  assign wr_rule.value_lo = req_i.addr_lo;
  assign wr_rule.mask_hi  = req_i.mask_hi;
  assign wr_rule.mask_lo  = req_i.mask_lo;
  assign wr_rule.kind_v4  = req_i.is_ipv4;
  assign wr_rule.tag      = req_i.rule_tag[mirfm_pkg::TAG_KEEP_W-1:0];

  // compare unit: one stored rule against the held lookup key
  assign kind_ok = (rd_q.kind_v4 == key_v4_q);
  always_comb begin
    if (key_v4_q) begin
      hit = ((key_hi_q & rd_q.mask_hi & mirfm_pkg::V4_HI_MASK) ==
             (rd_q.value_hi & mirfm_pkg::V4_HI_MASK));
    end else begin
      hit = ((key_hi_q & rd_q.mask_hi) == rd_q.value_hi) &&
            ((key_lo_q & rd_q.mask_lo) == rd_q.value_lo);
    end
    hit = hit && kind_ok;
  end

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.matched   = out_matched_q;
  assign rsp_o.flags_tag = out_tag_q;

  // rule memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[mirfm_pkg::IDX_W-1:0]] <= wr_rule;
    end
    rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      idx_q         <= '0;
      issue_q       <= 1'b0;
      pend_q        <= 1'b0;
      rd_last_q     <= 1'b0;
      key_v4_q      <= 1'b0;
      key_hi_q      <= '0;
      key_lo_q      <= '0;
      res_status_q  <= mirfm_pkg::STATUS_DONE;
      res_matched_q <= 1'b0;
      res_tag_q     <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= mirfm_pkg::STATUS_DONE;
      out_matched_q <= 1'b0;
      out_tag_q     <= '0;
    end else begin
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            key_v4_q      <= req_i.is_ipv4;
            key_hi_q      <= req_i.addr_hi;
            key_lo_q      <= req_i.addr_lo;
            res_status_q  <= mirfm_pkg::STATUS_DONE;
            res_matched_q <= 1'b0;
            res_tag_q     <= '0;
            idx_q         <= '0;
            pend_q        <= 1'b0;
            if (req_i.req_type == mirfm_pkg::REQ_APPEND) begin
              if (full) begin
                res_status_q <= mirfm_pkg::STATUS_FULL;
              end else begin
                count_q <= count_q + 1'b1;
              end
              state_q <= S_DONE;
            end else if (count_q == '0) begin
              state_q <= S_DONE;
            end else begin
              issue_q <= 1'b1;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // read of rule idx_q lands in rd_q in the next cycle
          if (issue_q) begin
            pend_q    <= 1'b1;
            rd_last_q <= last_idx;
            if (last_idx) begin
              issue_q <= 1'b0;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end else begin
            pend_q <= 1'b0;
          end
          if (pend_q) begin
            if (hit) begin
              res_matched_q <= 1'b1;
              res_tag_q     <= mirfm_pkg::TAG_W'(rd_q.tag);
              issue_q       <= 1'b0;
              pend_q        <= 1'b0;
              state_q       <= S_DONE;
            end else if (rd_last_q) begin
              issue_q <= 1'b0;
              pend_q  <= 1'b0;
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_status_q  <= res_status_q;
            out_matched_q <= res_matched_q;
            out_tag_q     <= res_tag_q;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- bench/masked_ip_rule_first_match_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_ip_rule_first_match_tb: self-checking bench of the masked IP rule table
// A table of directed rows goes first, then random appends and lookups. Most
// lookups are built from stored rules so that they hit deep in the table.
// The table fills until appends are refused. Both channels idle at random.
// Results are checked against a shadow copy of the rule table, or against the hand-written outcome of a typed row.
// ----------------------------------------------------------------------------

module masked_ip_rule_first_match_tb;
  import mirfm_pkg::*;

  typedef struct packed {
    logic              req_type;
    logic              is_ipv4;
    logic [WORD_W-1:0] addr_hi;
    logic [WORD_W-1:0] addr_lo;
    logic [WORD_W-1:0] mask_hi;
    logic [WORD_W-1:0] mask_lo;
    logic [TAG_W-1:0]  rule_tag;
  } req_item_t;

  typedef struct packed {
    logic             status;
    logic             matched;
    logic [TAG_W-1:0] flags_tag;
  } outcome_t;

  // directed row: request fields, then an optional hand-written outcome
  typedef struct packed {
    logic              req_type;
    logic              is_ipv4;
    logic [WORD_W-1:0] addr_hi;
    logic [WORD_W-1:0] addr_lo;
    logic [WORD_W-1:0] mask_hi;
    logic [WORD_W-1:0] mask_lo;
    logic [TAG_W-1:0]  rule_tag;
    logic              typed;
    logic              exp_status;
    logic              exp_matched;
    logic [TAG_W-1:0]  exp_tag;
  } dir_row_t;

  localparam logic [WORD_W-1:0] ONES = '1;
  localparam logic [WORD_W-1:0] ZERO = '0;
  localparam int unsigned DIR_N = 20;
  localparam int unsigned RANDOM_ITEMS = 1630;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // empty table: nothing can hit
    '{REQ_LOOKUP, 1'b0, ZERO, ZERO, ZERO, ZERO, 16'h0000, 1'b1, STATUS_DONE, 1'b0, 16'h0},
    '{REQ_LOOKUP, 1'b1, ONES, ONES, ONES, ONES, 16'hFFFF, 1'b1, STATUS_DONE, 1'b0, 16'h0},
    // v4 rule with value bits outside its mask: never hits
    '{REQ_APPEND, 1'b1, 64'h0A00_00FF_0000_0000, ZERO, 64'hFFFF_FF00_FFFF_FFFF, ONES,
      16'h4444, 1'b1, STATUS_DONE, 1'b0, 16'h0},
    // 192.168/16 with tag zero, junk in the uncompared low bits
    '{REQ_APPEND, 1'b1, 64'hC0A8_0000_DEAD_BEEF, ONES, 64'hFFFF_0000_1234_5678, ONES,
      16'h0000, 1'b1, STATUS_DONE, 1'b0, 16'h0},
    '{REQ_APPEND, 1'b1, 64'h0A00_0000_0000_0000, ZERO, 64'hFF00_0000_0000_0000, ZERO,
      16'hFFFF, 1'b1, STATUS_DONE, 1'b0, 16'h0},
    '{REQ_APPEND, 1'b0, 64'h2001_0DB8_0000_0000, ZERO, 64'hFFFF_FFFF_0000_0000, ZERO,
      16'hABCD, 1'b1, STATUS_DONE, 1'b0, 16'h0},
    '{REQ_APPEND, 1'b0, ONES, ONES, ZERO, ZERO, 16'h5555, 1'b1, STATUS_DONE, 1'b0, 16'h0},
    '{REQ_APPEND, 1'b0, ONES, ONES, ONES, ONES, 16'h8001, 1'b1, STATUS_DONE, 1'b0, 16'h0},
    // v6 rule that only looks at the last byte
    '{REQ_APPEND, 1'b0, ZERO, 64'h0000_0000_0000_00FF, ZERO, 64'h0000_0000_0000_00FF,
      16'h0F0F, 1'b1, STATUS_DONE, 1'b0, 16'h0},
    '{REQ_LOOKUP, 1'b1, 64'hC0A8_1234_0000_0000, ZERO, ZERO, ZERO, 16'h0,
      1'b1, STATUS_DONE, 1'b1, 16'h0},
    '{REQ_LOOKUP, 1'b1, 64'h0A00_00FF_5555_5555, ONES, ZERO, ZERO, 16'h0,
      1'b0, STATUS_DONE, 1'b0, 16'h0},
    '{REQ_LOOKUP, 1'b1, 64'h0B00_0000_0000_0000, ZERO, ZERO, ZERO, 16'h0,
      1'b0, STATUS_DONE, 1'b0, 16'h0},
    '{REQ_LOOKUP, 1'b0, 64'h2001_0DB8_FFFF_0000, 64'h1234, ZERO, ZERO, 16'h0,
      1'b0, STATUS_DONE, 1'b0, 16'h0},
    '{REQ_LOOKUP, 1'b0, ONES, ONES, ZERO, ZERO, 16'h0, 1'b0, STATUS_DONE, 1'b0, 16'h0},
    '{REQ_LOOKUP, 1'b0, 64'h1234_5678_9ABC_DEF0, 64'hFEDC_BA98_7654_32FF, ZERO, ZERO,
      16'h0, 1'b0, STATUS_DONE, 1'b0, 16'h0},
    '{REQ_LOOKUP, 1'b0, ZERO, ZERO, ONES, ONES, 16'h0, 1'b0, STATUS_DONE, 1'b0, 16'h0},
    // kind mismatch: v6 prefix looked up as v4, v4 prefix looked up as v6
    '{REQ_LOOKUP, 1'b1, 64'h2001_0DB8_0000_0000, ZERO, ZERO, ZERO, 16'h0,
      1'b0, STATUS_DONE, 1'b0, 16'h0},
    '{REQ_LOOKUP, 1'b0, 64'hC0A8_0000_DEAD_BEEF, ZERO, ZERO, ZERO, 16'h0,
      1'b0, STATUS_DONE, 1'b0, 16'h0},
    '{REQ_APPEND, 1'b1, ONES, ONES, ONES, ONES, 16'h0001, 1'b1, STATUS_DONE, 1'b0, 16'h0},
    '{REQ_LOOKUP, 1'b1, 64'hFFFF_FFFF_0000_0000, ZERO, ZERO, ZERO, 16'h0,
      1'b0, STATUS_DONE, 1'b0, 16'h0}
  };

  logic clk_i;
  logic rst_ni;

  mirfm_req_if req_if ();
  mirfm_rsp_if rsp_if ();

  masked_ip_rule_first_match u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow rule table
  rule_t       stored_rules [MAX_RULES];
  int unsigned rule_total;

  outcome_t outcome_q [$];
  int unsigned error_count;
  int unsigned n_stored, n_refused, n_hit, n_miss;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [127:0] prefix_mask(input int unsigned len);
    if (len == 0) return '0;
    return ~128'h0 << (128 - len);
  endfunction

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap(input int unsigned long_max);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(long_max, 10);
  endfunction

  function automatic outcome_t first_match_outcome(input req_item_t it);
    outcome_t    res;
    rule_t       r;
    int unsigned k;
    logic        hit;
    res = '{STATUS_DONE, 1'b0, '0};
    if (it.req_type == REQ_APPEND) begin
      if (rule_total >= MAX_RULES) begin
        res.status = STATUS_FULL;
        n_refused++;
      end else begin
        r.value_hi = it.addr_hi;
        r.value_lo = it.addr_lo;
        r.mask_hi  = it.mask_hi;
        r.mask_lo  = it.mask_lo;
        r.kind_v4  = it.is_ipv4;
        r.tag      = it.rule_tag[TAG_KEEP_W-1:0];
        stored_rules[rule_total] = r;
        rule_total++;
        n_stored++;
      end
    end else begin
      k = 0;
      while (k < rule_total && !res.matched) begin
        r = stored_rules[k];
        if (r.kind_v4 == it.is_ipv4) begin
          if (it.is_ipv4)
            hit = ((it.addr_hi & r.mask_hi & V4_HI_MASK) == (r.value_hi & V4_HI_MASK));
          else
            hit = ((it.addr_hi & r.mask_hi) == r.value_hi) &&
                  ((it.addr_lo & r.mask_lo) == r.value_lo);
          if (hit) begin
            res.matched   = 1'b1;
            res.flags_tag = TAG_W'(r.tag);
          end
        end
        k++;
      end
      if (res.matched) n_hit++;
      else n_miss++;
    end
    return res;
  endfunction

  function automatic req_item_t random_request();
    req_item_t    it;
    logic [127:0] m, v, a;
    rule_t        r;
    int unsigned  sel;
    it.mask_hi  = rand64();
    it.mask_lo  = rand64();
    it.addr_hi  = rand64();
    it.addr_lo  = rand64();
    it.is_ipv4  = 1'($urandom_range(1));
    it.rule_tag = TAG_W'($urandom_range(16'hFFFF));
    sel = $urandom_range(99);
    if (sel < 25) begin
      it.req_type = REQ_APPEND;
      if (sel < 20) begin
        // well-formed prefix rule; v4 lengths avoid a catch-all that hides the rest
        if (it.is_ipv4) m = prefix_mask($urandom_range(32, 8));
        else m = prefix_mask($urandom_range(128, 16));
        if (it.is_ipv4) begin
          it.mask_hi[63:32] = m[127:96];
          it.addr_hi[63:32] = it.addr_hi[63:32] & m[127:96];
        end else begin
          {it.mask_hi, it.mask_lo} = m;
          {it.addr_hi, it.addr_lo} = {it.addr_hi, it.addr_lo} & m;
        end
      end else if (sel < 22) begin
        it.addr_hi = it.addr_hi & it.mask_hi;
        it.addr_lo = it.addr_lo & it.mask_lo;
      end
      if ($urandom_range(49) == 0) it.rule_tag = '0;
    end else begin
      it.req_type = REQ_LOOKUP;
      if (rule_total > 0 && $urandom_range(99) < 70) begin
        r = stored_rules[$urandom_range(rule_total - 1)];
        it.is_ipv4 = r.kind_v4;
        m = {r.mask_hi, r.mask_lo};
        v = {r.value_hi, r.value_lo};
        a = {it.addr_hi, it.addr_lo};
        {it.addr_hi, it.addr_lo} = (v & m) | (a & ~m);
      end
    end
    return it;
  endfunction

  task automatic send_request(input req_item_t it, input logic typed, input outcome_t typed_res);
    int unsigned gap;
    outcome_t    res;
    gap = pick_gap(40);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= it.req_type;
    req_if.is_ipv4  <= it.is_ipv4;
    req_if.addr_hi  <= it.addr_hi;
    req_if.addr_lo  <= it.addr_lo;
    req_if.mask_hi  <= it.mask_hi;
    req_if.mask_lo  <= it.mask_lo;
    req_if.rule_tag <= it.rule_tag;
    do @(posedge clk_i); while (!req_if.ready);
    res = first_match_outcome(it);
    outcome_q.insert(outcome_q.size(), typed ? typed_res : res);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  // result side: ready runs with random stalls, now and then a long clean stretch
  initial begin : rsp_ready_gen
    int unsigned run_len;
    rsp_if.ready = 1'b0;
    forever begin
      if ($urandom_range(19) == 0) run_len = $urandom_range(800, 300);
      else run_len = $urandom_range(30, 1);
      repeat (run_len) begin
        @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end
      repeat (pick_gap(60)) begin
        @(posedge clk_i);
        rsp_if.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (outcome_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: result with nothing pending: status=%0d matched=%0d tag=%h",
                   $realtime, rsp_if.status, rsp_if.matched, rsp_if.flags_tag);
      end else begin
        want = outcome_q.pop_front();
        if (rsp_if.status !== want.status || rsp_if.matched !== want.matched ||
            rsp_if.flags_tag !== want.flags_tag) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: mismatch: exp status=%0d matched=%0d tag=%h, got %0d %0d %h",
                     $realtime, want.status, want.matched, want.flags_tag,
                     rsp_if.status, rsp_if.matched, rsp_if.flags_tag);
        end
      end
    end
  end

  initial begin : stimulus
    req_item_t it;
    outcome_t  typed_res;
    dir_row_t  row;
    rule_total  = 0;
    error_count = 0;
    n_stored    = 0;
    n_refused   = 0;
    n_hit       = 0;
    n_miss      = 0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_APPEND;
    req_if.is_ipv4  = 1'b0;
    req_if.addr_hi  = '0;
    req_if.addr_lo  = '0;
    req_if.mask_hi  = '0;
    req_if.mask_lo  = '0;
    req_if.rule_tag = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      row = DIR_ROWS[i];
      it = '{row.req_type, row.is_ipv4, row.addr_hi, row.addr_lo,
             row.mask_hi, row.mask_lo, row.rule_tag};
      typed_res = '{row.exp_status, row.exp_matched, row.exp_tag};
      send_request(it, row.typed, typed_res);
    end
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_request(random_request(), 1'b0, '0);
      if ($urandom_range(99) == 0) drain_results();
    end
    req_if.valid <= 1'b0;

    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    error_count += outcome_q.size();

    $display("covered: %0d rules stored, %0d appends refused on a full table",
             n_stored, n_refused);
    $display("covered: %0d lookups, %0d first-match hits, %0d misses",
             n_hit + n_miss, n_hit, n_miss);
    if (error_count == 0)
      $display("masked_ip_rule_first_match_tb: done, clean");
    else
      $display("masked_ip_rule_first_match_tb: done, errors");
    $finish;
  end

  initial begin : watchdog
    #(30_000_000);
    $display("masked_ip_rule_first_match_tb: done, errors");
    $finish;
  end

endmodule
